[hdl/gbn_pkg.sv]
// shared types and codes for the go-back-n receiver sequence tracker
package gbn_pkg;

	localparam int SEQ_W  = 32;
	localparam int TIME_W = 48;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq_num;
		logic [TIME_W-1:0] send_time;
	} pkt_t;

	typedef struct packed {
		logic              is_nack;
		logic [SEQ_W-1:0]  ack_edge;
		logic [TIME_W-1:0] echo_time;
	} resp_t;

	// position of an arriving packet relative to the ack edge
	typedef enum logic [1:0] {
		CLS_NEXT,
		CLS_DUP,
		CLS_WIN,
		CLS_GAP
	} pkt_class_t;

	typedef enum logic [5:0] {
		ST_CLEAR     = 6'b000001,
		ST_IDLE      = 6'b000010,
		ST_EVAL      = 6'b000100,
		ST_DRAIN_RD  = 6'b001000,
		ST_DRAIN_CHK = 6'b010000,
		ST_EMIT      = 6'b100000
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic do_next;
		logic do_mark;
		logic set_nack;
		logic rd_mark;
		logic drain_step;
		logic load_out;
		logic out_nack;
		logic out_from_seq;
	} cmd_t;

	typedef struct packed {
		pkt_class_t cls;
		logic       clr_last;
		logic       out_free;
		logic       mark_set;
		logic       nack_pend;
		logic       ooo;
	} status_t;

endpackage

[hdl/gbn_pkt_if.sv]
// data packet channel: valid, ready and packet header
interface gbn_pkt_if;
	import gbn_pkg::*;

	logic valid;
	logic ready;
	pkt_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/gbn_resp_if.sv]
// response channel: valid, ready and ack/nack payload
interface gbn_resp_if;
	import gbn_pkg::*;

	logic  valid;
	logic  ready;
	resp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/gbn_datapath.sv]
// sequence tracker datapath: ack edge, nack flag, reorder mark memory, output register
module gbn_datapath
	import gbn_pkg::*;
#(
	parameter int MAX_REORDER = 64,
	parameter int MARK_DEPTH  = 128
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic    cfg_wdata,
	input  pkt_t    pkt_data,
	input  logic    resp_ready,
	output logic    resp_valid,
	output resp_t   resp_data,
	input  cmd_t    cmd,
	output status_t sts
);

	localparam int IDX_W = $clog2(MARK_DEPTH);
	localparam int WIN   = (MAX_REORDER < MARK_DEPTH - 1) ? MAX_REORDER : MARK_DEPTH - 1;

	logic              ooo_q;
	logic [SEQ_W-1:0]  edge_q;
	logic [IDX_W-1:0]  edge_slot_q;
	logic              nack_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [TIME_W-1:0] time_q;
	logic [SEQ_W-1:0]  d_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic              rd_q;
	logic              out_valid_q;
	resp_t             out_q;

	logic              mark_mem [MARK_DEPTH];

	logic [IDX_W-1:0]  slot_inc;
	logic [IDX_W:0]    win_sum;
	logic [IDX_W-1:0]  win_slot;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic              wr_data;
	pkt_class_t        cls;

	// slot of edge+1, kept incrementally so no modulo is needed
	assign slot_inc = (edge_slot_q == IDX_W'(MARK_DEPTH - 1)) ? '0 : edge_slot_q + 1'b1;

	// d stays below the depth inside the window, one subtract folds it back
	assign win_sum  = {1'b0, edge_slot_q} + d_q[IDX_W:0];
	assign win_slot = (win_sum >= (IDX_W+1)'(MARK_DEPTH))
		? IDX_W'(win_sum - (IDX_W+1)'(MARK_DEPTH)) : win_sum[IDX_W-1:0];

	always_comb begin
		if (d_q == SEQ_W'(1)) begin
			cls = CLS_NEXT;
		end else if (d_q == '0 || d_q[SEQ_W-1]) begin
			cls = CLS_DUP;
		end else if (ooo_q && d_q <= SEQ_W'(WIN)) begin
			cls = CLS_WIN;
		end else begin
			cls = CLS_GAP;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_inc;
		wr_data = 1'b0;
		if (cmd.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
		end else if (cmd.do_next || cmd.drain_step) begin
			wr_en   = 1'b1;
		end else if (cmd.do_mark) begin
			wr_en   = 1'b1;
			wr_addr = win_slot;
			wr_data = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mark_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_mark) begin
			rd_q <= mark_mem[slot_inc];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ooo_q       <= 1'b0;
			edge_q      <= '0;
			edge_slot_q <= '0;
			nack_q      <= 1'b0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ooo_q <= cfg_wdata;
			end
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.do_next) begin
				edge_q      <= seq_q;
				edge_slot_q <= slot_inc;
				nack_q      <= 1'b0;
			end else if (cmd.drain_step) begin
				edge_q      <= edge_q + 1'b1;
				edge_slot_q <= slot_inc;
			end
			if (cmd.set_nack) begin
				nack_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (resp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			seq_q  <= pkt_data.seq_num;
			time_q <= pkt_data.send_time;
			d_q    <= pkt_data.seq_num - edge_q;
		end
		if (cmd.load_out) begin
			out_q.is_nack   <= cmd.out_nack;
			out_q.ack_edge  <= cmd.out_from_seq ? seq_q : edge_q;
			out_q.echo_time <= time_q;
		end
	end

	assign resp_valid = out_valid_q;
	assign resp_data  = out_q;

	assign sts.cls       = cls;
	assign sts.clr_last  = (clr_cnt_q == IDX_W'(MARK_DEPTH - 1));
	assign sts.out_free  = !out_valid_q || resp_ready;
	assign sts.mark_set  = rd_q;
	assign sts.nack_pend = nack_q;
	assign sts.ooo       = ooo_q;

endmodule

[hdl/gbn_ctrl.sv]
// sequence tracker controller: clearing pass, classify, drain, emit
module gbn_ctrl
	import gbn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pkt_valid,
	output logic    pkt_ready,
	input  status_t sts,
	output cmd_t    cmd,
	output state_t  state
);

	state_t st_q;
	state_t st_d;
	logic   kind_q;
	logic   kind_d;

	assign pkt_ready = (st_q == ST_IDLE);
	assign state     = st_q;

	always_comb begin
		cmd    = '0;
		st_d   = st_q;
		kind_d = kind_q;
		case (st_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pkt_valid) begin
					cmd.accept = 1'b1;
					st_d       = ST_EVAL;
				end
			end
			ST_EVAL: begin
				case (sts.cls)
					CLS_NEXT: begin
						cmd.do_next = 1'b1;
						kind_d      = 1'b0;
						if (sts.ooo) begin
							st_d = ST_DRAIN_RD;
						end else if (sts.out_free) begin
							cmd.load_out     = 1'b1;
							cmd.out_from_seq = 1'b1;
							st_d             = ST_IDLE;
						end else begin
							st_d = ST_EMIT;
						end
					end
					CLS_DUP: begin
						kind_d = 1'b0;
						if (sts.out_free) begin
							cmd.load_out = 1'b1;
							st_d         = ST_IDLE;
						end else begin
							st_d = ST_EMIT;
						end
					end
					CLS_WIN: begin
						cmd.do_mark = 1'b1;
						st_d        = ST_IDLE;
					end
					default: begin
						// gap outside the window, or any gap with out-of-order mode off: one nack until the edge moves
						if (sts.nack_pend) begin
							st_d = ST_IDLE;
						end else begin
							cmd.set_nack = 1'b1;
							kind_d       = 1'b1;
							if (sts.out_free) begin
								cmd.load_out = 1'b1;
								cmd.out_nack = 1'b1;
								st_d         = ST_IDLE;
							end else begin
								st_d = ST_EMIT;
							end
						end
					end
				endcase
			end
			ST_DRAIN_RD: begin
				cmd.rd_mark = 1'b1;
				st_d        = ST_DRAIN_CHK;
			end
			ST_DRAIN_CHK: begin
				if (sts.mark_set) begin
					cmd.drain_step = 1'b1;
					st_d           = ST_DRAIN_RD;
				end else if (sts.out_free) begin
					cmd.load_out = 1'b1;
					st_d         = ST_IDLE;
				end else begin
					st_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_nack = kind_q;
					st_d         = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			kind_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			kind_q <= kind_d;
		end
	end

endmodule

[hdl/gbn_receiver_psn_tracker_core.sv]
// top level of the go-back-n receiver sequence tracker
// response: registered from the evaluation state after its packet is accepted, or after the drain;
//   it waits in the emit state while the output register is still full. pkt.ready is high only when
//   idle, so one packet is handled at a time; the drain reads each mark through the mark read port
// reset: state and registers cleared at once, then a clearing pass over all MARK_DEPTH slots
//   zeroes the mark memory with pkt.ready low; configuration writes are taken throughout
module gbn_receiver_psn_tracker_core
	import gbn_pkg::*;
#(
	parameter int MAX_REORDER = 64,
	parameter int MARK_DEPTH  = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	gbn_pkt_if.sink       pkt,
	gbn_resp_if.source    resp
);

	cmd_t    cmd;
	status_t sts;
	state_t  state;

	gbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt.valid),
		.pkt_ready (pkt.ready),
		.sts       (sts),
		.cmd       (cmd),
		.state     (state)
	);

	gbn_datapath #(
		.MAX_REORDER (MAX_REORDER),
		.MARK_DEPTH  (MARK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pkt_data   (pkt.data),
		.resp_ready (resp.ready),
		.resp_valid (resp.valid),
		.resp_data  (resp.data),
		.cmd        (cmd),
		.sts        (sts)
	);

	// never overwrite a response that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("response register overwritten");

	// a drain step of the edge only comes after a mark was read
	a_drain_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain_step |-> $past(cmd.rd_mark))
		else $error("drain step without mark read");

	// no packet transaction while the mark memory is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !pkt.ready)
		else $error("packet accepted during clearing pass");

	// marks are only set for gaps inside the window with out-of-order mode on
	a_mark_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_mark |-> (sts.cls == CLS_WIN) && sts.ooo && (state == ST_EVAL))
		else $error("mark set outside the reorder window");

endmodule

[tb/sv/testbench.sv]
// testbench for the go-back-n receiver sequence tracker: directed cases and random traffic against a predictor
`timescale 1ns / 1ps

module testbench;
	import gbn_pkg::*;

	localparam int unsigned REORDER_SPAN = 64;
	localparam int unsigned MARK_SLOTS   = 128;
	localparam int unsigned WINDOW       = (REORDER_SPAN < MARK_SLOTS - 1) ?
		REORDER_SPAN : MARK_SLOTS - 1;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 16;

	// receiver state as the predictor sees it, plus the response of the last packet
	typedef struct packed {
		logic [SEQ_W-1:0]      ack_at;
		logic                  nack_sent;
		logic                  ooo;
		logic [MARK_SLOTS-1:0] marks;
		logic                  has_resp;
		resp_t                 resp;
	} tracker_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	gbn_pkt_if  pkt_if ();
	gbn_resp_if resp_if ();

	gbn_receiver_psn_tracker_core #(
		.MAX_REORDER (REORDER_SPAN),
		.MARK_DEPTH  (MARK_SLOTS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pkt       (pkt_if),
		.resp      (resp_if)
	);

	always #10 clk = ~clk;

	pkt_t     pkt_q[$];
	resp_t    ack_due_q[$];
	tracker_t chk = '0;
	tracker_t gen = '0;

	int  n_planned = 0;
	int  n_accepted = 0;
	int  n_resp_seen = 0;
	int  n_errors = 0;
	int  n_acks = 0, n_nacks = 0, n_buffered = 0, n_silent = 0;
	int  n_drains = 0, longest_drain = 0, n_cfg_writes = 0;
	int  quiet = 0;
	int  tx_gap = 0, rx_gap = 0, hold_left = 0, hold_trips = 0;
	bit  calm_run = 1'b0;

	function automatic int unsigned slot_of(logic [SEQ_W-1:0] s);
		return s % MARK_SLOTS;
	endfunction

	function automatic tracker_t advance_psn(tracker_t cur, pkt_t p);
		tracker_t         nx;
		logic [SEQ_W-1:0] lead;
		int               n;
		nx = cur;
		nx.has_resp = 1'b0;
		lead = p.seq_num - cur.ack_at;
		if (lead == 1) begin
			nx.ack_at = p.seq_num;
			nx.marks[slot_of(p.seq_num)] = 1'b0;
			n = 0;
			// pull the edge over every consecutive buffered packet
			while (nx.ooo && n < MARK_SLOTS && nx.marks[slot_of(nx.ack_at + 1)]) begin
				nx.ack_at = nx.ack_at + 1;
				nx.marks[slot_of(nx.ack_at)] = 1'b0;
				n++;
			end
			nx.nack_sent = 1'b0;
			nx.has_resp = 1'b1;
			nx.resp.is_nack = 1'b0;
		end else if (lead == 0 || lead[SEQ_W-1]) begin
			nx.has_resp = 1'b1;
			nx.resp.is_nack = 1'b0;
		end else if (nx.ooo && lead <= WINDOW) begin
			nx.marks[slot_of(p.seq_num)] = 1'b1;
		end else if (!nx.nack_sent) begin
			nx.nack_sent = 1'b1;
			nx.has_resp = 1'b1;
			nx.resp.is_nack = 1'b1;
		end
		nx.resp.ack_edge = nx.ack_at;
		nx.resp.echo_time = p.send_time;
		return nx;
	endfunction

	function automatic logic [TIME_W-1:0] rand_stamp();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return TIME_W'({$urandom, $urandom});
			end
		endcase
	endfunction

	task automatic queue_pkt(logic [SEQ_W-1:0] seq, logic [TIME_W-1:0] stamp);
		pkt_t p;
		p.seq_num = seq;
		p.send_time = stamp;
		gen = advance_psn(gen, p);
		pkt_q.push_back(p);
		n_planned++;
	endtask

	task automatic set_ooo(logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen.ooo = v;
		n_cfg_writes++;
	endtask

	// wait until every packet went in and every response came out, then let the block settle
	task automatic wait_idle();
		do @(negedge clk);
		while (n_accepted != n_planned || ack_due_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic flag_error(string msg);
		n_errors++;
		if (n_errors <= 10)
			$display("mismatch: %s", msg);
	endtask

	// sender model: mostly in-order runs and reordered blocks, with loss, dups and noise
	task automatic run_traffic(int count);
		int               ofs[16];
		int               k, j, tmp, goal, pick;
		logic [SEQ_W-1:0] base;
		goal = n_planned + count;
		while (n_planned < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				k = $urandom_range(1, 8);
				for (j = 0; j < k; j++)
					queue_pkt(gen.ack_at + 1, rand_stamp());
			end else if (pick < 62) begin
				k = $urandom_range(2, 12);
				base = gen.ack_at;
				for (j = 0; j < k; j++)
					ofs[j] = j + 1;
				for (j = k - 1; j > 0; j--) begin
					pick = $urandom_range(0, j);
					tmp = ofs[j];
					ofs[j] = ofs[pick];
					ofs[pick] = tmp;
				end
				// sometimes one packet of the block is lost
				pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, k - 1) : -1;
				for (j = 0; j < k; j++)
					if (j != pick)
						queue_pkt(base + ofs[j], rand_stamp());
			end else if (pick < 74) begin
				case ($urandom_range(0, 4))
					0: queue_pkt(gen.ack_at + WINDOW, rand_stamp());
					1: queue_pkt(gen.ack_at + WINDOW + 1, rand_stamp());
					2: queue_pkt(gen.ack_at + MARK_SLOTS, rand_stamp());
					default: queue_pkt(gen.ack_at + $urandom_range(2, 70), rand_stamp());
				endcase
			end else if (pick < 84) begin
				queue_pkt(gen.ack_at - $urandom_range(0, 200), rand_stamp());
			end else if (pick < 90) begin
				queue_pkt(gen.ack_at + $urandom_range(WINDOW + 1, 32'h7FFF_FFFF), rand_stamp());
			end else if (pick < 95) begin
				case ($urandom_range(0, 3))
					0: queue_pkt(gen.ack_at + 32'h7FFF_FFFF, rand_stamp());
					1: queue_pkt(gen.ack_at + 32'h8000_0000, rand_stamp());
					2: queue_pkt(gen.ack_at + 32'hFFFF_FFFF, rand_stamp());
					default: queue_pkt(gen.ack_at, rand_stamp());
				endcase
			end else begin
				queue_pkt($urandom, rand_stamp());
			end
		end
	endtask

	// packet driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_if.valid <= 1'b0;
			pkt_if.data <= '0;
			tx_gap = 0;
		end else if (!pkt_if.valid || pkt_if.ready) begin
			if (tx_gap > 0) begin
				tx_gap--;
				pkt_if.valid <= 1'b0;
			end else if (!calm_run && $urandom_range(0, 5) == 0) begin
				tx_gap = $urandom_range(0, 3);
				pkt_if.valid <= 1'b0;
			end else if (pkt_q.size() > 0) begin
				pkt_if.valid <= 1'b1;
				pkt_if.data <= pkt_q.pop_front();
			end else begin
				pkt_if.valid <= 1'b0;
			end
		end
	end

	// response ready: short random stalls, and now and then a long hold so the block backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_if.ready <= 1'b0;
			rx_gap = 0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			resp_if.ready <= 1'b0;
		end else if (!calm_run && hold_trips < 2 &&
				n_resp_seen >= (hold_trips == 0 ? 120 : 380)) begin
			hold_trips++;
			hold_left = 90;
			resp_if.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			resp_if.ready <= 1'b0;
		end else if (!calm_run && $urandom_range(0, 5) == 0) begin
			rx_gap = $urandom_range(0, 3);
			resp_if.ready <= 1'b0;
		end else begin
			resp_if.ready <= 1'b1;
		end
	end

	// monitor: predict on each packet transaction, check each response transaction
	always @(posedge clk) begin : monitor
		tracker_t nx;
		resp_t    want;
		resp_t    got;
		if (arst_n) begin
			if (cfg_we)
				chk.ooo = cfg_wdata;
			if (resp_if.valid && resp_if.ready) begin
				got = resp_if.data;
				if (ack_due_q.size() == 0) begin
					flag_error($sformatf("unexpected response nack=%0b edge=%0d echo=%h",
						got.is_nack, got.ack_edge, got.echo_time));
				end else begin
					want = ack_due_q.pop_front();
					if (got.is_nack !== want.is_nack || got.ack_edge !== want.ack_edge ||
							got.echo_time !== want.echo_time)
						flag_error($sformatf(
							"response %0d: expected nack=%0b edge=%0d echo=%h, got nack=%0b edge=%0d echo=%h",
							n_resp_seen, want.is_nack, want.ack_edge, want.echo_time,
							got.is_nack, got.ack_edge, got.echo_time));
				end
				n_resp_seen <= n_resp_seen + 1;
			end
			if (pkt_if.valid && pkt_if.ready) begin
				nx = advance_psn(chk, pkt_if.data);
				if (nx.has_resp) begin
					ack_due_q.push_back(nx.resp);
					if (nx.resp.is_nack)
						n_nacks++;
					else
						n_acks++;
				end else if (nx.marks != chk.marks) begin
					n_buffered++;
				end else begin
					n_silent++;
				end
				if (pkt_if.data.seq_num - chk.ack_at == 1 && nx.ack_at != pkt_if.data.seq_num) begin
					n_drains++;
					if (nx.ack_at - pkt_if.data.seq_num > longest_drain)
						longest_drain = nx.ack_at - pkt_if.data.seq_num;
				end
				chk = nx;
				n_accepted <= n_accepted + 1;
			end
		end
	end

	// watchdog on stretches with no transaction at all
	always @(posedge clk) begin
		if ((pkt_if.valid && pkt_if.ready) || (resp_if.valid && resp_if.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("no transaction for %0d cycles, %0d responses outstanding",
				quiet, ack_due_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// in-order, duplicate, half-space boundaries and nack suppression
		set_ooo(1'b0);
		queue_pkt(32'h0000_0000, '0);
		queue_pkt(32'hFFFF_FFFF, '1);
		queue_pkt(32'h0000_0001, 48'hAAAA_AAAA_AAAA);
		queue_pkt(32'h0000_0003, 48'h5555_5555_5555);
		queue_pkt(32'h0000_0005, rand_stamp());
		queue_pkt(32'h8000_0001, rand_stamp());
		queue_pkt(32'h8000_0000, rand_stamp());
		queue_pkt(32'h0000_0002, rand_stamp());
		queue_pkt(32'h8000_0001, rand_stamp());
		queue_pkt(32'h0000_0003, rand_stamp());
		wait_idle();

		// reorder window edges and a drain
		set_ooo(1'b1);
		queue_pkt(gen.ack_at + 2, rand_stamp());
		queue_pkt(gen.ack_at + WINDOW, rand_stamp());
		queue_pkt(gen.ack_at + WINDOW + 1, rand_stamp());
		queue_pkt(gen.ack_at + 3, rand_stamp());
		queue_pkt(gen.ack_at + 1, rand_stamp());
		queue_pkt(gen.ack_at, rand_stamp());
		queue_pkt(gen.ack_at + 2, rand_stamp());
		wait_idle();

		// a mark left behind when the mode goes off, then cleared in order
		set_ooo(1'b0);
		queue_pkt(gen.ack_at + 1, rand_stamp());
		queue_pkt(gen.ack_at + 1, rand_stamp());
		queue_pkt(gen.ack_at + MARK_SLOTS, rand_stamp());
		queue_pkt(gen.ack_at + 1, rand_stamp());
		wait_idle();

		set_ooo(1'b1);
		run_traffic(130);
		wait_idle();
		set_ooo(1'b0);
		run_traffic(120);
		wait_idle();
		set_ooo(1'b1);
		run_traffic(130);
		wait_idle();
		set_ooo(1'b0);
		run_traffic(100);
		wait_idle();
		set_ooo(1'b1);
		@(negedge clk);
		calm_run = 1'b1;
		run_traffic(100);
		wait_idle();

		$display("%0d packets: %0d acks, %0d nacks, %0d buffered out of order, %0d dropped silently",
			n_accepted, n_acks, n_nacks, n_buffered, n_silent);
		$display("ack edge ended at %0d after %0d drains (longest %0d), %0d mode writes",
			chk.ack_at, n_drains, longest_drain, n_cfg_writes);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[gbn_receiver_psn_tracker_core.f]
hdl/gbn_pkg.sv
hdl/gbn_pkt_if.sv
hdl/gbn_resp_if.sv
hdl/gbn_datapath.sv
hdl/gbn_ctrl.sv
hdl/gbn_receiver_psn_tracker_core.sv
tb/sv/testbench.sv
